// ===== sv/assert_macros.svh =====
// Assertion macros shared by the run queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds whenever ante holds, in the same cycle.
`define PRBRQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define PRBRQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/prbrq_pkg.sv =====
// Shared types and constants of the priority bitmap run queue.
package prbrq_pkg;

    localparam int THREAD_W    = 6;
    localparam int PRIO_W      = 6;
    localparam int IN_DATA_W   = ((THREAD_W + PRIO_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((THREAD_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_PICK   = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_QUEUED    = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_EMPTY     = 2'd3
    } status_t;

    localparam int OUT_USER_W = $bits(status_t) + 1;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_WALK,
        OP_RD_T,
        OP_RD_HEAD,
        OP_PICK_SEL,
        OP_PICK_NULL,
        OP_PICK_POP,
        OP_ADD_CLR,
        OP_ADD_LINK,
        OP_RM_HEAD,
        OP_RM_UNLINK,
        OP_RM_CLR,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    set_st;
        status_t st;
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  tid_ok;
        logic  head_hit;
        logic  map_any;
        logic  head_ok;
        logic  walk_found;
        logic  walk_end;
        logic  out_free;
    } dp_stat_t;

endpackage

// ===== sv/prbrq_dp.sv =====
// Datapath of the run queue: link memory, level head/tail tables, bitmap, output register.
`include "assert_macros.svh"

module prbrq_dp #(
    parameter int THREAD_SLOTS = 64,
    parameter int LEVELS       = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  prbrq_pkg::dp_cmd_t                cmd,
    output prbrq_pkg::dp_stat_t               stat,
    input  prbrq_pkg::mode_t                  in_mode,
    input  logic [prbrq_pkg::THREAD_W-1:0]    in_thread_id,
    input  logic [prbrq_pkg::PRIO_W-1:0]      in_priority_req,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output prbrq_pkg::status_t                m_status,
    output logic                              m_picked_valid,
    output logic [prbrq_pkg::THREAD_W-1:0]    m_picked_thread
);

    localparam int TW = $clog2(THREAD_SLOTS);
    localparam int LW = $clog2(LEVELS);
    localparam int SW = $clog2(THREAD_SLOTS + 1);
    localparam int IW = (TW >= prbrq_pkg::THREAD_W) ? TW + 1 : prbrq_pkg::THREAD_W + 1;

    // Latched command
    prbrq_pkg::mode_t   mode_reg;
    logic               tid_ok_reg;
    logic [TW-1:0]      t_reg;
    logic [LW-1:0]      lv_reg;
    prbrq_pkg::status_t status_reg;
    logic               picked_valid_reg;

    // Walker
    logic [SW-1:0]      steps_reg;
    logic               src_head_reg;
    logic [TW-1:0]      prev_reg;
    logic               prev_ok_reg;

    // Level tables and bitmap
    logic [TW-1:0]      head_id_reg [LEVELS];
    logic [TW-1:0]      tail_id_reg [LEVELS];
    logic [LEVELS-1:0]  head_ok_reg, head_ok_next;
    logic [LEVELS-1:0]  tail_ok_reg, tail_ok_next;
    logic [LEVELS-1:0]  map_reg, map_next;

    // Link memory: valid bit on top of the slot index
    logic [TW:0]        link_mem [THREAD_SLOTS];
    logic [TW:0]        rdata_reg;
    logic [TW-1:0]      rd_addr;
    logic               we;
    logic [TW-1:0]      waddr;
    logic [TW:0]        wdata;

    // Output register
    logic                           m_tvalid_reg, m_tvalid_next;
    prbrq_pkg::status_t             m_status_reg;
    logic                           m_pv_reg;
    logic [prbrq_pkg::THREAD_W-1:0] m_pt_reg;

    logic [IW-1:0]      tid_wide;
    logic [IW-1:0]      pt_wide;
    logic               in_tid_ok;
    logic [LW-1:0]      in_lv;
    logic [LW-1:0]      top_lv;
    logic               cur_ok;
    logic [TW-1:0]      cur_id;
    logic               walk_end;
    logic               walk_found;
    logic               head_cur_ok;
    logic [TW-1:0]      head_cur_id;
    logic               tail_cur_ok;
    logic [TW-1:0]      tail_cur_id;

    assign tid_wide  = IW'(in_thread_id);
    assign in_tid_ok = tid_wide < IW'(THREAD_SLOTS);
    assign in_lv     = (in_priority_req >= prbrq_pkg::PRIO_W'(LEVELS)) ? LW'(LEVELS - 1)
                                                                      : in_priority_req[LW-1:0];
    assign pt_wide   = IW'(t_reg);

    // Highest set level of the bitmap
    always_comb begin
        top_lv = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (map_reg[i]) begin
                top_lv = LW'(i);
            end
        end
    end

    assign head_cur_ok = head_ok_reg[lv_reg];
    assign head_cur_id = head_id_reg[lv_reg];
    assign tail_cur_ok = tail_ok_reg[lv_reg];
    assign tail_cur_id = tail_id_reg[lv_reg];

    // First link comes from the level head, later ones from the memory read data
    assign cur_ok     = src_head_reg ? head_cur_ok : rdata_reg[TW];
    assign cur_id     = src_head_reg ? head_cur_id : rdata_reg[TW-1:0];
    assign walk_end   = !cur_ok || (steps_reg == SW'(THREAD_SLOTS));
    assign walk_found = !walk_end && (cur_id == t_reg);

    always_comb begin
        case (cmd.op)
            prbrq_pkg::OP_WALK:    rd_addr = cur_id;
            prbrq_pkg::OP_RD_HEAD: rd_addr = head_cur_id;
            default:               rd_addr = t_reg;
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = t_reg;
        wdata = '0;
        case (cmd.op)
            prbrq_pkg::OP_ADD_CLR, prbrq_pkg::OP_RM_HEAD,
            prbrq_pkg::OP_RM_CLR, prbrq_pkg::OP_PICK_POP: begin
                we = 1'b1;
            end
            prbrq_pkg::OP_ADD_LINK: begin
                we    = tail_cur_ok;
                waddr = tail_cur_id;
                wdata = {1'b1, t_reg};
            end
            prbrq_pkg::OP_RM_UNLINK: begin
                we    = prev_ok_reg;
                waddr = prev_reg;
                wdata = rdata_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            link_mem[waddr] <= wdata;
        end
        rdata_reg <= link_mem[rd_addr];
    end

    always_comb begin
        head_ok_next  = head_ok_reg;
        tail_ok_next  = tail_ok_reg;
        map_next      = map_reg;
        case (cmd.op)
            prbrq_pkg::OP_PICK_NULL: begin
                map_next[lv_reg] = 1'b0;
            end
            prbrq_pkg::OP_PICK_POP, prbrq_pkg::OP_RM_HEAD: begin
                head_ok_next[lv_reg] = rdata_reg[TW];
                if (!rdata_reg[TW]) begin
                    tail_ok_next[lv_reg] = 1'b0;
                    map_next[lv_reg]     = 1'b0;
                end
            end
            prbrq_pkg::OP_ADD_LINK: begin
                if (!tail_cur_ok) begin
                    head_ok_next[lv_reg] = 1'b1;
                end
                tail_ok_next[lv_reg] = 1'b1;
                map_next[lv_reg]     = 1'b1;
            end
            default: begin
            end
        endcase
        if (cmd.op == prbrq_pkg::OP_EMIT) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_ok_reg  <= '0;
            tail_ok_reg  <= '0;
            map_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            head_ok_reg  <= head_ok_next;
            tail_ok_reg  <= tail_ok_next;
            map_reg      <= map_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            prbrq_pkg::OP_LOAD: begin
                mode_reg         <= in_mode;
                tid_ok_reg       <= in_tid_ok;
                t_reg            <= tid_wide[TW-1:0];
                lv_reg           <= in_lv;
                status_reg       <= prbrq_pkg::STATUS_DONE;
                picked_valid_reg <= 1'b0;
                steps_reg        <= '0;
                src_head_reg     <= 1'b1;
                prev_ok_reg      <= 1'b0;
            end
            prbrq_pkg::OP_WALK: begin
                if (!walk_end && !walk_found) begin
                    prev_reg     <= cur_id;
                    prev_ok_reg  <= 1'b1;
                    steps_reg    <= steps_reg + SW'(1);
                    src_head_reg <= 1'b0;
                end
            end
            prbrq_pkg::OP_RD_HEAD: begin
                t_reg <= head_cur_id;
            end
            prbrq_pkg::OP_PICK_SEL: begin
                lv_reg <= top_lv;
            end
            prbrq_pkg::OP_PICK_POP: begin
                head_id_reg[lv_reg] <= rdata_reg[TW-1:0];
                picked_valid_reg    <= 1'b1;
            end
            prbrq_pkg::OP_RM_HEAD: begin
                head_id_reg[lv_reg] <= rdata_reg[TW-1:0];
            end
            prbrq_pkg::OP_ADD_LINK: begin
                if (!tail_cur_ok) begin
                    head_id_reg[lv_reg] <= t_reg;
                end
                tail_id_reg[lv_reg] <= t_reg;
            end
            prbrq_pkg::OP_RM_UNLINK: begin
                // Retarget the tail when the removed thread was last
                if (prev_ok_reg && tail_cur_ok && (tail_cur_id == t_reg)) begin
                    tail_id_reg[lv_reg] <= prev_reg;
                end
                status_reg <= prev_ok_reg ? prbrq_pkg::STATUS_DONE
                                          : prbrq_pkg::STATUS_NOT_FOUND;
            end
            prbrq_pkg::OP_EMIT: begin
                m_status_reg <= status_reg;
                m_pv_reg     <= picked_valid_reg;
                m_pt_reg     <= picked_valid_reg ? pt_wide[prbrq_pkg::THREAD_W-1:0] : '0;
            end
            default: begin
            end
        endcase
        if (cmd.set_st) begin
            status_reg <= cmd.st;
        end
    end

    assign stat.mode       = mode_reg;
    assign stat.tid_ok     = tid_ok_reg;
    assign stat.head_hit   = head_cur_ok && (head_cur_id == t_reg);
    assign stat.map_any    = |map_reg;
    assign stat.head_ok    = head_cur_ok;
    assign stat.walk_found = walk_found;
    assign stat.walk_end   = walk_end;
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid        = m_tvalid_reg;
    assign m_status        = m_status_reg;
    assign m_picked_valid  = m_pv_reg;
    assign m_picked_thread = m_pt_reg;

    `PRBRQ_ASSERT_NOW(a_steps_bounded, aclk, aresetn,
        src_head_reg == 1'b0, steps_reg <= SW'(THREAD_SLOTS), "walk ran past the slot count")
    `PRBRQ_ASSERT_NEXT(a_add_marks_level, aclk, aresetn, cmd.op == prbrq_pkg::OP_ADD_LINK,
        map_reg[$past(lv_reg)] && head_ok_reg[$past(lv_reg)], "append left level unmarked")
    `PRBRQ_ASSERT_NOW(a_pick_is_done, aclk, aresetn, m_tvalid_reg && m_pv_reg,
        m_status_reg == prbrq_pkg::STATUS_DONE, "picked thread with non-done status")

endmodule

// ===== sv/prbrq_ctrl.sv =====
// Controller state machine of the run queue: sequences the datapath per command.
`include "assert_macros.svh"

module prbrq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  prbrq_pkg::dp_stat_t stat,
    output prbrq_pkg::dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_WALK_ADD,
        ST_ADD_LINK,
        ST_RM_HEAD,
        ST_WALK_RM,
        ST_RM_UNLINK,
        ST_RM_CLR,
        ST_PICK_CHK,
        ST_PICK_POP,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = prbrq_pkg::OP_NONE;
        cmd.set_st = 1'b0;
        cmd.st     = prbrq_pkg::STATUS_DONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = prbrq_pkg::OP_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (stat.mode)
                    prbrq_pkg::MODE_PICK: begin
                        if (stat.map_any) begin
                            cmd.op     = prbrq_pkg::OP_PICK_SEL;
                            state_next = ST_PICK_CHK;
                        end else begin
                            cmd.set_st = 1'b1;
                            cmd.st     = prbrq_pkg::STATUS_EMPTY;
                            state_next = ST_RESULT;
                        end
                    end
                    prbrq_pkg::MODE_ADD, prbrq_pkg::MODE_REMOVE: begin
                        if (!stat.tid_ok) begin
                            cmd.set_st = 1'b1;
                            cmd.st     = prbrq_pkg::STATUS_NOT_FOUND;
                            state_next = ST_RESULT;
                        end else if (stat.mode == prbrq_pkg::MODE_ADD) begin
                            state_next = ST_WALK_ADD;
                        end else if (stat.head_hit) begin
                            cmd.op     = prbrq_pkg::OP_RD_T;
                            state_next = ST_RM_HEAD;
                        end else begin
                            state_next = ST_WALK_RM;
                        end
                    end
                    default: begin
                        cmd.set_st = 1'b1;
                        cmd.st     = prbrq_pkg::STATUS_DONE;
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_WALK_ADD: begin
                if (stat.walk_found) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = prbrq_pkg::STATUS_QUEUED;
                    state_next = ST_RESULT;
                end else if (stat.walk_end) begin
                    cmd.op     = prbrq_pkg::OP_ADD_CLR;
                    state_next = ST_ADD_LINK;
                end else begin
                    cmd.op = prbrq_pkg::OP_WALK;
                end
            end
            ST_ADD_LINK: begin
                cmd.op     = prbrq_pkg::OP_ADD_LINK;
                cmd.set_st = 1'b1;
                cmd.st     = prbrq_pkg::STATUS_DONE;
                state_next = ST_RESULT;
            end
            ST_RM_HEAD: begin
                cmd.op     = prbrq_pkg::OP_RM_HEAD;
                cmd.set_st = 1'b1;
                cmd.st     = prbrq_pkg::STATUS_DONE;
                state_next = ST_RESULT;
            end
            ST_WALK_RM: begin
                if (stat.walk_found) begin
                    cmd.op     = prbrq_pkg::OP_RD_T;
                    state_next = ST_RM_UNLINK;
                end else if (stat.walk_end) begin
                    cmd.op     = prbrq_pkg::OP_RM_CLR;
                    cmd.set_st = 1'b1;
                    cmd.st     = prbrq_pkg::STATUS_NOT_FOUND;
                    state_next = ST_RESULT;
                end else begin
                    cmd.op = prbrq_pkg::OP_WALK;
                end
            end
            ST_RM_UNLINK: begin
                cmd.op     = prbrq_pkg::OP_RM_UNLINK;
                state_next = ST_RM_CLR;
            end
            ST_RM_CLR: begin
                cmd.op     = prbrq_pkg::OP_RM_CLR;
                state_next = ST_RESULT;
            end
            ST_PICK_CHK: begin
                if (stat.head_ok) begin
                    cmd.op     = prbrq_pkg::OP_RD_HEAD;
                    state_next = ST_PICK_POP;
                end else begin
                    cmd.op     = prbrq_pkg::OP_PICK_NULL;
                    cmd.set_st = 1'b1;
                    cmd.st     = prbrq_pkg::STATUS_EMPTY;
                    state_next = ST_RESULT;
                end
            end
            ST_PICK_POP: begin
                cmd.op     = prbrq_pkg::OP_PICK_POP;
                cmd.set_st = 1'b1;
                cmd.st     = prbrq_pkg::STATUS_DONE;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    cmd.op     = prbrq_pkg::OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    `PRBRQ_ASSERT_NEXT(a_accept_dispatch, aclk, aresetn, s_tvalid && s_tready,
        state_reg == ST_DISPATCH, "accepted item not dispatched")
    `PRBRQ_ASSERT_NEXT(a_walk_holds, aclk, aresetn,
        state_reg == ST_WALK_ADD && !stat.walk_found && !stat.walk_end,
        state_reg == ST_WALK_ADD, "add walk left early")
    `PRBRQ_ASSERT_NEXT(a_result_waits, aclk, aresetn,
        state_reg == ST_RESULT && !stat.out_free,
        state_reg == ST_RESULT, "result dropped while output busy")

endmodule

// ===== sv/priority_bitmap_run_queue.sv =====
// To m_tvalid: an empty pick, unused mode or bad slot goes from dispatch to the result; a
// remove at the head passes ST_RM_HEAD; a pick checks its level head in ST_PICK_CHK and pops
// it in ST_PICK_POP unless null; add and remove walk their level's list one link per cycle,
// up to THREAD_SLOTS links; a full output register adds its wait. Throughput: one item at a
// time; the next is taken once the last result is in the output register, even while it
// waits for m_tready. Reset: aresetn (synchronous, active low) clears every level and bitmap.

module priority_bitmap_run_queue #(
    parameter int THREAD_SLOTS = 64,  // thread slots in the link memory (2 to 64)
    parameter int LEVELS       = 32   // priority levels in the bitmap (2 to 32)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Command items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [prbrq_pkg::IN_DATA_W-1:0]      s_tdata,   // thread_id, priority_req, zero pad
    input  logic [$bits(prbrq_pkg::mode_t)-1:0]  s_tuser,   // mode
    // Result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [prbrq_pkg::OUT_DATA_W-1:0]     m_tdata,   // picked_thread, zero pad
    output logic [prbrq_pkg::OUT_USER_W-1:0]     m_tuser    // status, picked_valid
);

    prbrq_pkg::dp_cmd_t                 cmd;
    prbrq_pkg::dp_stat_t                stat;
    prbrq_pkg::mode_t                   in_mode;
    logic [prbrq_pkg::THREAD_W-1:0]     in_thread_id;
    logic [prbrq_pkg::PRIO_W-1:0]       in_priority_req;
    prbrq_pkg::status_t                 m_status;
    logic                               m_picked_valid;
    logic [prbrq_pkg::THREAD_W-1:0]     m_picked_thread;

    // Unpack the command item: thread slot in the low bits, then the priority
    assign in_mode         = prbrq_pkg::mode_t'(s_tuser);
    assign in_thread_id    = s_tdata[prbrq_pkg::THREAD_W-1:0];
    assign in_priority_req = s_tdata[prbrq_pkg::THREAD_W +: prbrq_pkg::PRIO_W];

    // The controller steps through the list walk and the table updates; it only sees
    // status flags from the datapath and drives it with one operation per cycle.
    prbrq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the per-slot links, the per-level head and tail, the level
    // bitmap and the output register that parts the result side from the command side.
    prbrq_dp #(
        .THREAD_SLOTS (THREAD_SLOTS),
        .LEVELS       (LEVELS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .in_mode         (in_mode),
        .in_thread_id    (in_thread_id),
        .in_priority_req (in_priority_req),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .m_status        (m_status),
        .m_picked_valid  (m_picked_valid),
        .m_picked_thread (m_picked_thread)
    );

    // Pack the result item; pad the thread slot up to a whole byte
    assign m_tdata = {{(prbrq_pkg::OUT_DATA_W - prbrq_pkg::THREAD_W){1'b0}}, m_picked_thread};
    assign m_tuser = {m_picked_valid, m_status};

endmodule
